// ===== src/looping_ima_adpcm_channel_defines.svh =====
// Assertion macros shared by the looping IMA ADPCM channel.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef LOOPING_IMA_ADPCM_CHANNEL_DEFINES_SVH
`define LOOPING_IMA_ADPCM_CHANNEL_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LIAC_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LIAC_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/liac_pkg.sv =====
// Package for the looping IMA ADPCM channel: codes, result type, step table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package liac_pkg;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LOOP_POINT = 2'd0;
    localparam logic [1:0] REG_LENGTH     = 2'd1;
    localparam logic [1:0] REG_REPEAT     = 2'd2;

    // Repeat modes; the other codes run on.
    localparam logic [1:0] MODE_LOOP    = 2'd1;
    localparam logic [1:0] MODE_ONESHOT = 2'd2;

    // Input item kinds carried on tuser.
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_DATA  = 1'b1;

    // Field widths.
    localparam int LP_W   = 18;
    localparam int LEN_W  = 24;
    localparam int OFS_W  = 25;
    localparam int IN_W   = 32;
    localparam int OUT_W  = 48;

    // Index and predictor limits.
    localparam logic [6:0]          INDEX_MAX  = 7'd88;
    localparam logic signed [17:0]  PRED_MAX_W = 18'sd32767;
    localparam logic signed [17:0]  PRED_MIN_W = -18'sd32767;
    localparam logic signed [15:0]  PRED_MAX   = 16'sh7FFF;
    localparam logic signed [15:0]  PRED_MIN   = -16'sh7FFF;
    localparam logic [OFS_W-1:0]    START_OFS  = 25'd4;

    // One decoded nibble as it leaves for the output register.
    typedef struct packed {
        logic signed [15:0] sample;
        logic [OFS_W-1:0]   offset;
        logic               active;
        logic               last;
    } result_t;

    // IMA ADPCM step size for a clamped index.
    function automatic logic [15:0] step_lookup(input logic [6:0] idx);
        logic [15:0] s;
        unique case (idx)
            7'd0:  s = 16'h0007; 7'd1:  s = 16'h0008; 7'd2:  s = 16'h0009; 7'd3:  s = 16'h000A;
            7'd4:  s = 16'h000B; 7'd5:  s = 16'h000C; 7'd6:  s = 16'h000D; 7'd7:  s = 16'h000E;
            7'd8:  s = 16'h0010; 7'd9:  s = 16'h0011; 7'd10: s = 16'h0013; 7'd11: s = 16'h0015;
            7'd12: s = 16'h0017; 7'd13: s = 16'h0019; 7'd14: s = 16'h001C; 7'd15: s = 16'h001F;
            7'd16: s = 16'h0022; 7'd17: s = 16'h0025; 7'd18: s = 16'h0029; 7'd19: s = 16'h002D;
            7'd20: s = 16'h0032; 7'd21: s = 16'h0037; 7'd22: s = 16'h003C; 7'd23: s = 16'h0042;
            7'd24: s = 16'h0049; 7'd25: s = 16'h0050; 7'd26: s = 16'h0058; 7'd27: s = 16'h0061;
            7'd28: s = 16'h006B; 7'd29: s = 16'h0076; 7'd30: s = 16'h0082; 7'd31: s = 16'h008F;
            7'd32: s = 16'h009D; 7'd33: s = 16'h00AD; 7'd34: s = 16'h00BE; 7'd35: s = 16'h00D1;
            7'd36: s = 16'h00E6; 7'd37: s = 16'h00FD; 7'd38: s = 16'h0117; 7'd39: s = 16'h0133;
            7'd40: s = 16'h0151; 7'd41: s = 16'h0173; 7'd42: s = 16'h0198; 7'd43: s = 16'h01C1;
            7'd44: s = 16'h01EE; 7'd45: s = 16'h0220; 7'd46: s = 16'h0256; 7'd47: s = 16'h0292;
            7'd48: s = 16'h02D4; 7'd49: s = 16'h031C; 7'd50: s = 16'h036C; 7'd51: s = 16'h03C3;
            7'd52: s = 16'h0424; 7'd53: s = 16'h048E; 7'd54: s = 16'h0502; 7'd55: s = 16'h0583;
            7'd56: s = 16'h0610; 7'd57: s = 16'h06AB; 7'd58: s = 16'h0756; 7'd59: s = 16'h0812;
            7'd60: s = 16'h08E0; 7'd61: s = 16'h09C3; 7'd62: s = 16'h0ABD; 7'd63: s = 16'h0BD0;
            7'd64: s = 16'h0CFF; 7'd65: s = 16'h0E4C; 7'd66: s = 16'h0FBA; 7'd67: s = 16'h114C;
            7'd68: s = 16'h1307; 7'd69: s = 16'h14EE; 7'd70: s = 16'h1706; 7'd71: s = 16'h1954;
            7'd72: s = 16'h1BDC; 7'd73: s = 16'h1EA5; 7'd74: s = 16'h21B6; 7'd75: s = 16'h2515;
            7'd76: s = 16'h28CA; 7'd77: s = 16'h2CDF; 7'd78: s = 16'h315B; 7'd79: s = 16'h364B;
            7'd80: s = 16'h3BB9; 7'd81: s = 16'h41B2; 7'd82: s = 16'h4844; 7'd83: s = 16'h4F7E;
            7'd84: s = 16'h5771; 7'd85: s = 16'h602F; 7'd86: s = 16'h69CE; 7'd87: s = 16'h7462;
            7'd88: s = 16'h7FFF;
            default: s = 16'h7FFF;
        endcase
        return s;
    endfunction

    // Step index change for the low three code bits.
    function automatic logic signed [7:0] index_move(input logic [2:0] code);
        logic signed [7:0] m;
        if (code[2])
        begin
            m = 8'sd2 + $signed({5'b0, code[1:0], 1'b0});
        end
        else
        begin
            m = -8'sd1;
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== src/looping_ima_adpcm_channel.sv =====
// Top level of the looping IMA ADPCM channel: input register, channel state,
// loop control. Depends on liac_pkg, liac_nibble, liac_outreg and the defines header.
`timescale 1ns / 1ps
`default_nettype none

`include "looping_ima_adpcm_channel_defines.svh"

// One channel decoding 4-bit IMA ADPCM with a loop. A start transaction on an
// idle channel loads the header predictor and index and arms it; each data
// transaction of a playing channel yields up to two samples, low nibble first,
// each the predictor before its nibble, with the offset of the next byte to
// fetch. The nibbles of one byte go through a single decoder, and samples leave
// the output, one per clock when neither side stalls. Input and output
// registers decouple both sides, so the next byte is taken in the cycle its
// predecessor's high nibble is decoded. Configuration must be written only
// while the channel holds no pending work; the block does not enforce this.
module looping_ima_adpcm_channel
    import liac_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // Configuration write port
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [LEN_W-1:0] cfg_data,
    // Input stream
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // header_sample[15:0], header_index[22:16],
                                             // data_byte[30:23], zero[31]
    input  wire logic             s_tuser,   // action
    // Output stream
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // sample_out[15:0], next_offset[40:16],
                                             // still_active[41], zeros[47:42]
    output logic                  m_tlast    // last_of_byte
);

    // Configuration registers
    logic [LP_W-1:0]    lp_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [1:0]         mode_reg;

    // Input register
    logic               in_valid_reg;
    logic               in_valid_next;
    logic               in_action_reg;
    logic signed [15:0] in_hs_reg;
    logic [6:0]         in_hi_reg;
    logic [7:0]         in_byte_reg;
    logic               phase_reg;
    logic               phase_next;

    // Channel state
    logic signed [15:0] pred_reg;
    logic signed [7:0]  idx_reg;
    logic signed [15:0] sv_pred_reg;
    logic signed [7:0]  sv_idx_reg;
    logic [OFS_W-1:0]   ofs_reg;
    logic               playing_reg;

    // Nibble step
    logic [3:0]         code;
    logic signed [15:0] pn;
    logic signed [7:0]  inx;
    logic [OFS_W-1:0]   ofs_inc;
    logic [OFS_W-1:0]   lp_ext;
    logic [OFS_W-1:0]   end_ofs;
    logic               save_hit;
    logic               at_end;
    logic               do_loop;
    logic               do_stop;
    logic signed [15:0] sv_pred_n;
    logic signed [7:0]  sv_idx_n;
    logic signed [15:0] pred_n;
    logic signed [7:0]  idx_n;
    logic [OFS_W-1:0]   ofs_n;
    logic               play_n;

    // Handshake control
    logic               accept;
    logic               emits;
    logic               slot_free;
    logic               fire;
    logic               done;
    logic               push;
    result_t            res;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_reg   <= '0;
            len_reg  <= '0;
            mode_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LOOP_POINT: lp_reg   <= cfg_data[LP_W-1:0];
                REG_LENGTH:     len_reg  <= cfg_data;
                REG_REPEAT:     mode_reg <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    // Shared nibble decoder
    assign code = phase_reg ? in_byte_reg[7:4] : in_byte_reg[3:0];

    liac_nibble u_nib (
        .pred      (pred_reg),
        .idx       (idx_reg),
        .code      (code),
        .pred_next (pn),
        .idx_next  (inx)
    );

    // Offset advance, loop-point save and end-of-loop handling.
    assign ofs_inc   = phase_reg ? ofs_reg + OFS_W'(1) : ofs_reg;
    assign lp_ext    = {{(OFS_W-LP_W){1'b0}}, lp_reg};
    assign end_ofs   = {{(OFS_W-LEN_W){1'b0}}, len_reg} + lp_ext;
    assign save_hit  = phase_reg && (ofs_inc == lp_ext);
    assign at_end    = (ofs_inc >= end_ofs);
    assign do_loop   = at_end && (mode_reg == MODE_LOOP);
    assign do_stop   = at_end && (mode_reg == MODE_ONESHOT);
    assign sv_pred_n = save_hit ? pn  : sv_pred_reg;
    assign sv_idx_n  = save_hit ? inx : sv_idx_reg;
    assign pred_n    = do_loop ? sv_pred_n : pn;
    assign idx_n     = do_loop ? sv_idx_n  : inx;
    assign ofs_n     = do_loop ? lp_ext    : ofs_inc;
    assign play_n    = !do_stop;

    // A data byte of a playing channel produces results; all else finishes at once.
    assign emits     = (in_action_reg == ACT_DATA) && playing_reg;
    assign fire      = in_valid_reg && (!emits || slot_free);
    assign done      = !emits || phase_reg || !play_n;
    assign push      = fire && emits;
    assign s_tready  = !in_valid_reg || (fire && done);
    assign accept    = s_tvalid && s_tready;

    assign in_valid_next = accept ? 1'b1 : ((fire && done) ? 1'b0 : in_valid_reg);
    assign phase_next    = (push && !done) ? 1'b1 : ((fire && done) ? 1'b0 : phase_reg);

    assign res.sample = pred_reg;
    assign res.offset = ofs_n;
    assign res.active = play_n;
    assign res.last   = phase_reg;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            phase_reg    <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            phase_reg    <= phase_next;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_action_reg <= s_tuser;
            in_hs_reg     <= s_tdata[15:0];
            in_hi_reg     <= s_tdata[22:16];
            in_byte_reg   <= s_tdata[30:23];
        end
    end

    // Channel state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pred_reg    <= '0;
            idx_reg     <= '0;
            sv_pred_reg <= '0;
            sv_idx_reg  <= '0;
            ofs_reg     <= '0;
            playing_reg <= 1'b0;
        end
        else if (fire)
        begin
            priority if (push)
            begin
                pred_reg    <= pred_n;
                idx_reg     <= idx_n;
                sv_pred_reg <= sv_pred_n;
                sv_idx_reg  <= sv_idx_n;
                ofs_reg     <= ofs_n;
                playing_reg <= play_n;
            end
            else if ((in_action_reg == ACT_START) && !playing_reg)
            begin
                pred_reg    <= in_hs_reg;
                idx_reg     <= $signed({1'b0, in_hi_reg});
                sv_pred_reg <= in_hs_reg;
                sv_idx_reg  <= $signed({1'b0, in_hi_reg});
                ofs_reg     <= START_OFS;
                playing_reg <= 1'b1;
            end
            else
            begin
                playing_reg <= playing_reg;
            end
        end
    end

    liac_outreg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .res      (res),
        .free     (slot_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // The high nibble is only pending inside a data byte of a playing channel.
    `LIAC_ASSERT_IMP(a_phase_in_data, phase_reg,
        in_valid_reg && (in_action_reg == ACT_DATA) && playing_reg,
        "high nibble pending outside a playing data byte")

    // A low nibble that leaves the channel playing is followed by its high nibble.
    `LIAC_ASSERT_NXT(a_low_then_high, push && !phase_reg && play_n,
        phase_reg && in_valid_reg,
        "high nibble missing after low nibble")

    // The stored index stays between one below zero and the header maximum; the check covers the lower bound.
    `LIAC_ASSERT_IMP(a_index_range, 1'b1, idx_reg >= -8'sd1,
        "step index out of range")

endmodule

`default_nettype wire

// ===== src/liac_nibble.sv =====
// Combinational IMA ADPCM nibble decoder: clamps the index, scales the step,
// saturates the predictor. Depends on liac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module liac_nibble
    import liac_pkg::*;
(
    input  wire logic signed [15:0] pred,
    input  wire logic signed [7:0]  idx,
    input  wire logic [3:0]         code,
    output logic signed [15:0]      pred_next,
    output logic signed [7:0]       idx_next
);

    logic [6:0]         idx_c;
    logic [15:0]        step;
    logic [16:0]        diff;
    logic signed [17:0] pred_ext;
    logic signed [17:0] diff_ext;
    logic signed [17:0] wide;

    // Clamp the stored index to the table range before use.
    always_comb
    begin
        if (idx[7])
        begin
            idx_c = 7'd0;
        end
        else if (idx[6:0] > INDEX_MAX)
        begin
            idx_c = INDEX_MAX;
        end
        else
        begin
            idx_c = idx[6:0];
        end
    end

    assign step = step_lookup(idx_c);

    // Scaled difference from the three magnitude bits.
    assign diff = {4'b0, step[15:3]}
                + (code[0] ? {3'b0, step[15:2]} : 17'd0)
                + (code[1] ? {2'b0, step[15:1]} : 17'd0)
                + (code[2] ? {1'b0, step}       : 17'd0);

    assign pred_ext = {{2{pred[15]}}, pred};
    assign diff_ext = $signed({1'b0, diff});

    // Move the predictor and saturate on the side it moved toward.
    always_comb
    begin
        if (code[3])
        begin
            wide      = pred_ext - diff_ext;
            pred_next = (wide < PRED_MIN_W) ? PRED_MIN : wide[15:0];
        end
        else
        begin
            wide      = pred_ext + diff_ext;
            pred_next = (wide > PRED_MAX_W) ? PRED_MAX : wide[15:0];
        end
    end

    assign idx_next = $signed({1'b0, idx_c}) + index_move(code[2:0]);

endmodule

`default_nettype wire

// ===== src/liac_outreg.sv =====
// Output register of the channel: holds one decoded sample until taken.
// Depends on liac_pkg.
`timescale 1ns / 1ps
`default_nettype none

module liac_outreg
    import liac_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire result_t          res,
    output logic                  free,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata,   // sample_out[15:0], next_offset[40:16],
                                             // still_active[41], zeros[47:42]
    output logic                  m_tlast    // last_of_byte
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // The slot can take a new result when empty or emptied this cycle.
    assign free       = !valid_reg || m_tready;
    assign valid_next = push ? 1'b1 : (m_tready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload is loaded only on a push.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {6'b0, res_reg.active, res_reg.offset, res_reg.sample};
    assign m_tlast  = res_reg.last;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for the looping IMA ADPCM channel: a directed table followed by random
// phases, every output transaction checked against a decoder model kept here.
// Depends on liac_pkg and the looping_ima_adpcm_channel top level.

module testbench;
    import liac_pkg::*;

    // Repeat modes that simply run on; the package names only loop and one-shot.
    localparam logic [1:0] MODE_RUN_ON     = 2'd0;
    localparam logic [1:0] MODE_RUN_ON_ALT = 2'd3;

    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 200;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_ITEMS   = 100;
    localparam int MAX_REPORTS   = 40;

    // IMA ADPCM step sizes, indexed by the clamped step index.
    localparam int STEP_SIZES [89] = '{
        'h0007, 'h0008, 'h0009, 'h000A, 'h000B, 'h000C, 'h000D, 'h000E, 'h0010, 'h0011,
        'h0013, 'h0015, 'h0017, 'h0019, 'h001C, 'h001F, 'h0022, 'h0025, 'h0029, 'h002D,
        'h0032, 'h0037, 'h003C, 'h0042, 'h0049, 'h0050, 'h0058, 'h0061, 'h006B, 'h0076,
        'h0082, 'h008F, 'h009D, 'h00AD, 'h00BE, 'h00D1, 'h00E6, 'h00FD, 'h0117, 'h0133,
        'h0151, 'h0173, 'h0198, 'h01C1, 'h01EE, 'h0220, 'h0256, 'h0292, 'h02D4, 'h031C,
        'h036C, 'h03C3, 'h0424, 'h048E, 'h0502, 'h0583, 'h0610, 'h06AB, 'h0756, 'h0812,
        'h08E0, 'h09C3, 'h0ABD, 'h0BD0, 'h0CFF, 'h0E4C, 'h0FBA, 'h114C, 'h1307, 'h14EE,
        'h1706, 'h1954, 'h1BDC, 'h1EA5, 'h21B6, 'h2515, 'h28CA, 'h2CDF, 'h315B, 'h364B,
        'h3BB9, 'h41B2, 'h4844, 'h4F7E, 'h5771, 'h602F, 'h69CE, 'h7462, 'h7FFF
    };

    // One row of stimulus: either an input transaction or a register write.
    typedef struct {
        bit                 is_reg;
        logic               act;
        logic [15:0]        hs;
        logic [6:0]         hi;
        logic [7:0]         db;
        bit                 typed;
        result_t            first;
        logic [1:0]         reg_idx;
        logic [LEN_W-1:0]   reg_val;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [LEN_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_W-1:0]      s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_W-1:0]     m_tdata;
    logic                 m_tlast;

    // Samples still owed by the channel, oldest first.
    result_t pending_samples[$];
    int      error_count = 0;

    // Decoder state and register copies.
    int                 cur_pred  = 0;
    int                 cur_idx   = 0;
    int                 loop_pred = 0;
    int                 loop_idx  = 0;
    logic [OFS_W-1:0]   fetch_ofs = '0;
    bit                 is_playing = 1'b0;
    logic [LP_W-1:0]    loop_start = '0;
    logic [LEN_W-1:0]   loop_len   = '0;
    logic [1:0]         loop_mode  = MODE_RUN_ON;

    // Idling controls shared by the sender and the receiver.
    bit gaps_on    = 1'b1;
    bit stalls_on  = 1'b1;
    bit hold_req   = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left  = 0;
    int stall_left = 0;

    looping_ima_adpcm_channel dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Decode one code: clamp the index, move the predictor with saturation, move the index.
    function automatic void apply_code(logic [3:0] code);
        int step;
        int diff;
        int moved;
        if (cur_idx < 0)
            cur_idx = 0;
        else if (cur_idx > int'(INDEX_MAX))
            cur_idx = int'(INDEX_MAX);
        step = STEP_SIZES[cur_idx];
        diff = step >>> 3;
        if (code[0])
            diff += step >>> 2;
        if (code[1])
            diff += step >>> 1;
        if (code[2])
            diff += step;
        if (code[3])
        begin
            moved    = cur_pred - diff;
            cur_pred = (moved < int'(PRED_MIN)) ? int'(PRED_MIN) : moved;
        end
        else
        begin
            moved    = cur_pred + diff;
            cur_pred = (moved > int'(PRED_MAX)) ? int'(PRED_MAX) : moved;
        end
        if (code[2])
            cur_idx += 2 + 2 * int'(code[1:0]);
        else
            cur_idx -= 1;
    endfunction

    // At or past the loop end, loop mode jumps back and restores, one-shot mode stops.
    function automatic void check_loop_end();
        logic [LEN_W:0] end_ofs;
        end_ofs = loop_start + loop_len;
        if (fetch_ofs >= end_ofs)
        begin
            if (loop_mode == MODE_LOOP)
            begin
                fetch_ofs = loop_start;
                cur_pred  = loop_pred;
                cur_idx   = loop_idx;
            end
            else if (loop_mode == MODE_ONESHOT)
            begin
                is_playing = 1'b0;
            end
        end
    endfunction

    // Apply one accepted transaction and queue the samples it yields.
    // Returns whether the transaction had any effect on the channel.
    function automatic bit predict_samples(logic act, logic [15:0] hs, logic [6:0] hi,
                                           logic [7:0] db);
        result_t    r;
        logic [3:0] code;
        if (act == ACT_START)
        begin
            if (is_playing)
                return 1'b0;
            cur_pred   = int'($signed(hs));
            cur_idx    = int'(hi);
            loop_pred  = cur_pred;
            loop_idx   = cur_idx;
            fetch_ofs  = START_OFS;
            is_playing = 1'b1;
            return 1'b1;
        end
        if (!is_playing)
            return 1'b0;
        for (int nib = 0; nib < 2; nib++)
        begin
            code     = (nib == 0) ? db[3:0] : db[7:4];
            r.sample = cur_pred[15:0];
            apply_code(code);
            if (nib == 1)
            begin
                fetch_ofs = fetch_ofs + 1'b1;
                if (fetch_ofs == loop_start)
                begin
                    loop_pred = cur_pred;
                    loop_idx  = cur_idx;
                end
            end
            check_loop_end();
            r.offset = fetch_ofs;
            r.active = is_playing;
            r.last   = (nib == 1);
            pending_samples.push_back(r);
            if (!is_playing)
                break;
        end
        return 1'b1;
    endfunction

    function automatic stim_row_t start_row(logic [15:0] hs, logic [6:0] hi);
        stim_row_t r;
        r     = '{default: '0};
        r.act = ACT_START;
        r.hs  = hs;
        r.hi  = hi;
        r.db  = 8'($urandom);
        return r;
    endfunction

    function automatic stim_row_t data_row(logic [7:0] db);
        stim_row_t r;
        r     = '{default: '0};
        r.act = ACT_DATA;
        r.hs  = 16'($urandom);
        r.hi  = 7'($urandom);
        r.db  = db;
        return r;
    endfunction

    // Data row whose first sample is known by inspection: still playing, low nibble.
    function automatic stim_row_t checked_row(logic [7:0] db, logic [15:0] sample,
                                              logic [OFS_W-1:0] offset);
        stim_row_t r;
        r       = data_row(db);
        r.typed = 1'b1;
        r.first = '{sample: sample, offset: offset, active: 1'b1, last: 1'b0};
        return r;
    endfunction

    function automatic stim_row_t reg_row(logic [1:0] idx, logic [LEN_W-1:0] val);
        stim_row_t r;
        r         = '{default: '0};
        r.is_reg  = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 3))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Byte styles: plain random, both codes rising, both codes falling.
    function automatic logic [7:0] pick_byte(int style);
        case (style)
            1:       return 8'($urandom) & 8'h77;
            2:       return 8'($urandom) | 8'h88;
            default: return 8'($urandom);
        endcase
    endfunction

    // Offer one input transaction, wait for acceptance, then predict its samples.
    task automatic offer_item(input stim_row_t row);
        int gap;
        int base;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.act;
        s_tdata  <= {1'b0, row.db, row.hi, row.hs};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        base = pending_samples.size();
        void'(predict_samples(row.act, row.hs, row.hi, row.db));
        if (row.typed && pending_samples.size() > base)
            pending_samples[base] = row.first;
    endtask

    // Let every owed sample arrive, then give the channel time to go idle.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [LEN_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_LOOP_POINT: loop_start = val[LP_W-1:0];
            REG_LENGTH:     loop_len   = val;
            REG_REPEAT:     loop_mode  = val[1:0];
            default:        ;
        endcase
        @(posedge clk);
    endtask

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                         $time, name, want, got);
        end
    endfunction

    // Receiver: random stall bursts, one long hold-off on request, otherwise ready.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            m_tready  <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (stalls_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 3);
            m_tready  <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    // Compare every output transaction with the oldest owed sample.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_samples.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected output transaction, expected none, actual 0x%0h",
                             $time, m_tdata);
            end
            else
            begin
                want = pending_samples.pop_front();
                compare_field("sample_out", 32'(want.sample[15:0]), 32'(m_tdata[15:0]));
                compare_field("next_offset", 32'(want.offset), 32'(m_tdata[40:16]));
                compare_field("still_active", 32'(want.active), 32'(m_tdata[41]));
                compare_field("last_of_byte", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // Run limit.
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        stim_row_t          table_rows[$];
        int                 done;
        int                 nbytes;
        int                 style;
        logic [LP_W-1:0]    lp;
        logic [LEN_W-1:0]   ln;
        logic [1:0]         md;

        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_LOOP_POINT;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_DATA;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Registers start at zero, so the channel runs on.
        table_rows.push_back(data_row(8'hFF));                    // idle: ignored
        table_rows.push_back(start_row(16'h7FFF, 7'd127));        // index above the table
        table_rows.push_back(start_row(16'h8000, 7'd0));          // playing: ignored
        table_rows.push_back(checked_row(8'h77, 16'h7FFF, START_OFS));
        table_rows.push_back(data_row(8'h00));
        table_rows.push_back(data_row(8'hFF));
        table_rows.push_back(data_row(8'h88));
        table_rows.push_back(data_row(8'hF8));
        // One-shot with the end already passed: stops after the low nibble.
        table_rows.push_back(reg_row(REG_REPEAT, LEN_W'(MODE_ONESHOT)));
        table_rows.push_back(data_row(8'h12));
        table_rows.push_back(data_row(8'h34));                    // stopped: ignored
        // One-shot ending on a whole byte; the start drives the lower bound.
        table_rows.push_back(reg_row(REG_LENGTH, 24'd8));
        table_rows.push_back(start_row(16'h8000, 7'd0));
        table_rows.push_back(checked_row(8'hFF, 16'h8000, START_OFS));
        table_rows.push_back(data_row(8'h0F));
        table_rows.push_back(data_row(8'hF0));
        table_rows.push_back(data_row(8'h80));
        // Loop from byte 8 to byte 12 and back.
        table_rows.push_back(reg_row(REG_LOOP_POINT, 24'd8));
        table_rows.push_back(reg_row(REG_LENGTH, 24'd4));
        table_rows.push_back(reg_row(REG_REPEAT, LEN_W'(MODE_LOOP)));
        table_rows.push_back(start_row(16'd100, 7'd10));
        for (int i = 0; i < 9; i++)
            table_rows.push_back(data_row(8'(8'h1F + 8'h0F * i)));

        foreach (table_rows[i])
        begin
            if (table_rows[i].is_reg)
            begin
                settle();
                write_reg(table_rows[i].reg_idx, table_rows[i].reg_val);
            end
            else
            begin
                offer_item(table_rows[i]);
            end
        end

        // Random phases, each with its own register setting.
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle();
            gaps_on   = (phase < 8) && (phase != 2);
            stalls_on = (phase < 8) && (phase != 3);

            // A channel that still plays ignores starts; stop it with a one-shot end.
            if (is_playing)
            begin
                write_reg(REG_LOOP_POINT, '0);
                write_reg(REG_LENGTH, '0);
                write_reg(REG_REPEAT, LEN_W'(MODE_ONESHOT));
                offer_item(data_row(8'($urandom)));
                settle();
            end

            if (phase == 0)
            begin
                lp = 18'h3FFFC;
                ln = 24'hFFFFFC;
                md = MODE_RUN_ON_ALT;
            end
            else if (phase == 1)
            begin
                lp = '0;
                ln = '0;
                md = MODE_LOOP;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       lp = '0;
                    1:       lp = LP_W'(4 * $urandom_range(1, 8));
                    default: lp = {16'($urandom), 2'b00};
                endcase
                case ($urandom_range(0, 2))
                    0:       ln = '0;
                    1:       ln = LEN_W'(4 * $urandom_range(1, 12));
                    default: ln = {22'($urandom), 2'b00};
                endcase
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: md = MODE_LOOP;
                    4, 5, 6, 7: md = MODE_ONESHOT;
                    8:          md = MODE_RUN_ON;
                    default:    md = MODE_RUN_ON_ALT;
                endcase
            end
            write_reg(REG_LOOP_POINT, LEN_W'(lp));
            write_reg(REG_LENGTH, ln);
            write_reg(REG_REPEAT, LEN_W'(md));

            // The long hold-off starts while the sender keeps offering this phase's items.
            if (phase == 5)
                hold_req = 1'b1;

            // Mostly a start followed by a run of bytes; the rest is loose noise.
            done = 0;
            while (done < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 8)
                begin
                    offer_item(start_row(pick_sample(), 7'($urandom_range(0, 127))));
                    done++;
                    style  = $urandom_range(0, 3);
                    nbytes = $urandom_range(1, 40);
                    repeat (nbytes)
                    begin
                        offer_item(data_row(pick_byte(style)));
                        done++;
                    end
                end
                else if ($urandom_range(0, 1) == 0)
                begin
                    offer_item(start_row(16'($urandom), 7'($urandom)));
                    done++;
                end
                else
                begin
                    offer_item(data_row(8'($urandom)));
                    done++;
                end
            end
        end

        settle();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
